// ===== rtl/petd_pkg.sv =====
// shared types and constants of the periodic event task dispatcher
package petd_pkg;

	// default table depth and the most dispatches one scan may give
	localparam int MAX_TASKS_DEF = 16;
	localparam int RESULT_LIMIT  = 16;
	localparam int HIT_W         = $clog2(RESULT_LIMIT + 1);

	// operation codes of the input transfer
	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_SCAN  = 3'd1,
		OP_ADD   = 3'd2,
		OP_RAISE = 3'd3,
		OP_SET   = 3'd4,
		OP_READ  = 3'd5
	} op_t;

	// task life-cycle states
	typedef enum logic [1:0] {
		TS_INIT = 2'd0,
		TS_IDLE = 2'd1,
		TS_EXEC = 2'd2,
		TS_DEAD = 2'd3
	} tstate_t;

	// dispatch action codes of a result
	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_INIT = 2'd1,
		ACT_EXEC = 2'd2
	} action_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK_RD,
		S_TICK_EV,
		S_SCAN,
		S_SCAN_END,
		S_RESP
	} fsm_t;

	// one timer table entry
	typedef struct packed {
		logic [31:0] period;
		logic [31:0] last;
	} timer_entry_t;

endpackage

// ===== rtl/periodic_event_task_dispatcher_unit.sv =====
// top level of the periodic event task dispatcher: task table, tick clock, sequencer
//
// Usage: one input channel (in_valid/in_ready) carries an operation with its
// task_id, task_kind, period_ticks and new_state fields; one output channel
// (out_valid/out_ready) returns results with action, task_index, task_status,
// table_full and last. last marks the final result of each input transfer.
// The block takes one input at a time and drops in_ready until that input's
// results are all loaded into the output register.
// Add, raise, set state, read state and unused codes give a single result. A tick
// steps through the registered tasks: each registered task costs a timer memory
// read and one pass through the shared add-and-compare unit. A scan walks one task
// per cycle under the flag and state flops while the receiver does not stall it,
// with at most sixteen dispatches.
// Results go through one output register; a scan holds back one result so the
// final one can carry last. When the receiver stalls, the walk pauses on the
// next dispatch and the table is left unchanged until it moves on.
// Reset clears the task count, the tick clock, the pending flags and both
// channels; the per-task table needs no clearing pass.
module periodic_event_task_dispatcher_unit #(
	parameter int MAX_TASKS = petd_pkg::MAX_TASKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [3:0]  task_id,
	input  logic        task_kind,
	input  logic [31:0] period_ticks,
	input  logic [1:0]  new_state,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  action,
	output logic [3:0]  task_index,
	output logic [1:0]  task_status,
	output logic        table_full,
	output logic        last
);

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int HIT_W = petd_pkg::HIT_W;

	// control state
	petd_pkg::fsm_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      time_q;
	logic [IDX_W-1:0] idx_q;
	logic [HIT_W-1:0] hits_q;
	logic [MAX_TASKS-1:0] pend_q;

	// latched input transfer
	petd_pkg::op_t op_q;
	logic [3:0]    id_q;
	logic          kind_q;
	logic [31:0]   period_q;
	logic [1:0]    nst_q;

	// per-task state and kind
	logic [1:0] tstate_q [MAX_TASKS];
	logic       tkind_q  [MAX_TASKS];

	// held scan result
	logic       hold_v_q;
	logic [1:0] hold_act_q;
	logic [3:0] hold_idx_q;
	logic [1:0] hold_st_q;

	// output register
	logic       out_valid_q;
	logic [1:0] out_act_q;
	logic [3:0] out_idx_q;
	logic [1:0] out_st_q;
	logic       out_full_q;
	logic       out_last_q;

	// timer memory
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	petd_pkg::timer_entry_t mem_wdata;
	petd_pkg::timer_entry_t mem_rdata;

	// comb control
	logic             accept;
	logic             out_free;
	logic [IDX_W-1:0] sel;
	logic [IDX_W-1:0] id_slot;
	logic [IDX_W-1:0] add_slot;
	logic [1:0]       cur_st;
	logic             cur_kind;
	logic             cur_pend;
	logic             id_ok;
	logic             tbl_full;
	logic             at_end;
	logic [31:0]      due_sum;
	logic             due;
	logic             fire;
	logic             scan_hit;
	logic             scan_stall;
	logic             out_load;
	logic [1:0]       ld_act;
	logic [3:0]       ld_idx;
	logic [1:0]       ld_st;
	logic             ld_full;
	logic             ld_last;
	logic             resp_go;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == petd_pkg::S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// table lookups at the walk index or the addressed task
	assign id_slot  = IDX_W'(id_q);
	assign add_slot = IDX_W'(count_q);
	assign sel      = (state_q == petd_pkg::S_RESP) ? id_slot : idx_q;
	assign cur_st   = tstate_q[sel];
	assign cur_kind = tkind_q[sel];
	assign cur_pend = pend_q[sel];
	assign id_ok    = (CNT_W + 4)'(id_q) < (CNT_W + 4)'(count_q);
	assign tbl_full = (CNT_W + 1)'(count_q) >= (CNT_W + 1)'(MAX_TASKS);
	assign at_end   = CNT_W'(idx_q) == (count_q - CNT_W'(1));

	// shared add-and-compare unit: due when now >= last + period, modulo 2^32
	assign due_sum = mem_rdata.last + mem_rdata.period;
	assign due     = time_q >= due_sum;
	assign fire    = (state_q == petd_pkg::S_TICK_EV) && cur_kind && due;

	// scan decision for the task under the walk index
	assign scan_hit = (cur_st == petd_pkg::TS_INIT) ||
		((cur_st == petd_pkg::TS_IDLE) && cur_pend);
	assign scan_stall = scan_hit && hold_v_q && !out_free;
	assign resp_go = (state_q == petd_pkg::S_RESP) && out_free;

	// timer memory write: fire stamp on tick, fresh entry on add
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '{period: mem_rdata.period, last: time_q};
		if (fire) begin
			mem_we = 1'b1;
		end else if (resp_go && (op_q == petd_pkg::OP_ADD) && !tbl_full) begin
			mem_we    = 1'b1;
			mem_waddr = add_slot;
			mem_wdata = '{period: kind_q ? period_q : 32'd0, last: 32'd0};
		end
	end

	petd_timer_ram #(
		.DEPTH  (MAX_TASKS),
		.ADDR_W (IDX_W)
	) u_timer_ram (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (idx_q),
		.rd_data (mem_rdata)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= petd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and output register load
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		ld_act   = petd_pkg::ACT_NONE;
		ld_idx   = 4'd0;
		ld_st    = 2'd0;
		ld_full  = 1'b0;
		ld_last  = 1'b0;
		unique case (state_q)
			petd_pkg::S_IDLE: begin
				if (accept) begin
					case (operation)
						petd_pkg::OP_TICK: begin
							state_d = (count_q == '0) ? petd_pkg::S_RESP : petd_pkg::S_TICK_RD;
						end
						petd_pkg::OP_SCAN: begin
							state_d = (count_q == '0) ? petd_pkg::S_SCAN_END : petd_pkg::S_SCAN;
						end
						default: begin
							state_d = petd_pkg::S_RESP;
						end
					endcase
				end
			end
			petd_pkg::S_TICK_RD: begin
				state_d = petd_pkg::S_TICK_EV;
			end
			petd_pkg::S_TICK_EV: begin
				state_d = at_end ? petd_pkg::S_RESP : petd_pkg::S_TICK_RD;
			end
			petd_pkg::S_SCAN: begin
				if (!scan_stall) begin
					if (scan_hit && hold_v_q) begin
						out_load = 1'b1;
						ld_act   = hold_act_q;
						ld_idx   = hold_idx_q;
						ld_st    = hold_st_q;
					end
					if (at_end || (scan_hit && (hits_q == HIT_W'(petd_pkg::RESULT_LIMIT - 1)))) begin
						state_d = petd_pkg::S_SCAN_END;
					end
				end
			end
			petd_pkg::S_SCAN_END: begin
				if (out_free) begin
					out_load = 1'b1;
					ld_last  = 1'b1;
					if (hold_v_q) begin
						ld_act = hold_act_q;
						ld_idx = hold_idx_q;
						ld_st  = hold_st_q;
					end
					state_d = petd_pkg::S_IDLE;
				end
			end
			petd_pkg::S_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					ld_last  = 1'b1;
					case (op_q) inside
						petd_pkg::OP_ADD: begin
							ld_full = tbl_full;
							ld_idx  = tbl_full ? 4'd0 : 4'(count_q);
						end
						petd_pkg::OP_RAISE, petd_pkg::OP_READ: begin
							ld_idx = id_q;
							ld_st  = id_ok ? cur_st : 2'd0;
						end
						petd_pkg::OP_SET: begin
							ld_idx = id_q;
							ld_st  = id_ok ? nst_q : 2'd0;
						end
						default: begin
						end
					endcase
					state_d = petd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = petd_pkg::S_IDLE;
			end
		endcase
	end

	// control registers: count, clock, walk index, held result, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			time_q      <= '0;
			idx_q       <= '0;
			hits_q      <= '0;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				idx_q  <= '0;
				hits_q <= '0;
				if (operation == petd_pkg::OP_TICK) begin
					time_q <= time_q + 32'd1;
				end
			end
			if (state_q == petd_pkg::S_TICK_EV) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if ((state_q == petd_pkg::S_SCAN) && !scan_stall) begin
				idx_q <= idx_q + IDX_W'(1);
				if (scan_hit) begin
					hold_v_q <= 1'b1;
					hits_q   <= hits_q + HIT_W'(1);
				end
			end
			if ((state_q == petd_pkg::S_SCAN_END) && out_free) begin
				hold_v_q <= 1'b0;
			end
			if (resp_go && (op_q == petd_pkg::OP_ADD) && !tbl_full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// pending flags: set by tick and raise, cleared by exec dispatch and add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			if (fire) begin
				pend_q[idx_q] <= 1'b1;
			end
			if ((state_q == petd_pkg::S_SCAN) && !scan_stall && scan_hit &&
				(cur_st == petd_pkg::TS_IDLE)) begin
				pend_q[idx_q] <= 1'b0;
			end
			if (resp_go && (op_q == petd_pkg::OP_ADD) && !tbl_full) begin
				pend_q[add_slot] <= 1'b0;
			end
			if (resp_go && (op_q == petd_pkg::OP_RAISE) && id_ok) begin
				pend_q[id_slot] <= 1'b1;
			end
		end
	end

	// latched transfer, task state and kind, held result, output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= petd_pkg::op_t'(operation);
			id_q     <= task_id;
			kind_q   <= task_kind;
			period_q <= period_ticks;
			nst_q    <= new_state;
		end
		if ((state_q == petd_pkg::S_SCAN) && !scan_stall && scan_hit) begin
			hold_idx_q <= 4'(idx_q);
			if (cur_st == petd_pkg::TS_INIT) begin
				tstate_q[idx_q] <= petd_pkg::TS_IDLE;
				hold_act_q      <= petd_pkg::ACT_INIT;
				hold_st_q       <= petd_pkg::TS_IDLE;
			end else begin
				tstate_q[idx_q] <= petd_pkg::TS_EXEC;
				hold_act_q      <= petd_pkg::ACT_EXEC;
				hold_st_q       <= petd_pkg::TS_EXEC;
			end
		end
		if (resp_go && (op_q == petd_pkg::OP_ADD) && !tbl_full) begin
			tstate_q[add_slot] <= petd_pkg::TS_INIT;
			tkind_q[add_slot]  <= kind_q;
		end
		if (resp_go && (op_q == petd_pkg::OP_SET) && id_ok) begin
			tstate_q[id_slot] <= nst_q;
		end
		if (out_load) begin
			out_act_q  <= ld_act;
			out_idx_q  <= ld_idx;
			out_st_q   <= ld_st;
			out_full_q <= ld_full;
			out_last_q <= ld_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign action      = out_act_q;
	assign task_index  = out_idx_q;
	assign task_status = out_st_q;
	assign table_full  = out_full_q;
	assign last        = out_last_q;

	// table never grows past its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W + 1)'(count_q) <= (CNT_W + 1)'(MAX_TASKS))
		else $error("task count beyond table depth");

	// a scan never dispatches more than the result limit
	a_hits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(HIT_W + 1)'(hits_q) <= (HIT_W + 1)'(petd_pkg::RESULT_LIMIT))
		else $error("scan dispatch count beyond limit");

	// one input at a time: busy straight after a transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input taken while previous one still in work");

	// a held scan result only lives inside a scan
	a_hold_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> ((state_q == petd_pkg::S_SCAN) || (state_q == petd_pkg::S_SCAN_END)))
		else $error("held scan result outside scan");

	// the output register is never overwritten while it waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !out_load)
		else $error("stalled result overwritten");

endmodule

// ===== rtl/petd_timer_ram.sv =====
// timer table memory: period and last-fire time per task, registered read
module petd_timer_ram #(
	parameter int DEPTH  = petd_pkg::MAX_TASKS_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [ADDR_W-1:0]     wr_addr,
	input  petd_pkg::timer_entry_t wr_data,
	input  logic [ADDR_W-1:0]     rd_addr,
	output petd_pkg::timer_entry_t rd_data
);

	petd_pkg::timer_entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered output
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== tb/tb.sv =====
// testbench of the periodic event task dispatcher: queued stimulus, table predictor, result check
module tb;

	localparam int        CYCLE_LIMIT = 200000;
	localparam int        RAND_ITEMS  = 160;
	localparam int        TAIL_ITEMS  = 30;
	localparam int        HOLD_CYCLES = 400;
	localparam int        DRAIN_WAIT  = 40;
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	// one operation as offered on the input channel
	typedef struct {
		logic [2:0]  op;
		logic [3:0]  id;
		logic        kind;
		logic [31:0] period;
		logic [1:0]  nst;
	} sched_op_t;

	// one dispatch result as it should leave the block
	typedef struct {
		petd_pkg::action_t act;
		logic [3:0]        idx;
		petd_pkg::tstate_t st;
		logic              full;
		logic              is_last;
	} sched_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  operation = '0;
	logic [3:0]  task_id = '0;
	logic        task_kind = 1'b0;
	logic [31:0] period_ticks = '0;
	logic [1:0]  new_state = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  action;
	logic [3:0]  task_index;
	logic [1:0]  task_status;
	logic        table_full;
	logic        last;

	sched_op_t     op_q[$];
	sched_result_t result_q[$];
	int            fail_cnt;
	int            accepted_cnt;
	int            cycle_cnt;
	int            send_gap;
	int            stall_left;
	int            hold_left;
	bit            hold_done;

	// predictor copy of the task table and tick clock
	petd_pkg::tstate_t task_st [petd_pkg::MAX_TASKS_DEF];
	logic        task_timer [petd_pkg::MAX_TASKS_DEF];
	logic        task_pend [petd_pkg::MAX_TASKS_DEF];
	logic [31:0] task_period [petd_pkg::MAX_TASKS_DEF];
	logic [31:0] task_fired [petd_pkg::MAX_TASKS_DEF];
	int          task_cnt;
	logic [31:0] tick_now;

	periodic_event_task_dispatcher_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.task_id      (task_id),
		.task_kind    (task_kind),
		.period_ticks (period_ticks),
		.new_state    (new_state),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action       (action),
		.task_index   (task_index),
		.task_status  (task_status),
		.table_full   (table_full),
		.last         (last)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic void expect_result(petd_pkg::action_t a, logic [3:0] idx,
			petd_pkg::tstate_t s, logic full);
		sched_result_t r;
		r.act     = a;
		r.idx     = idx;
		r.st      = s;
		r.full    = full;
		r.is_last = 1'b0;
		result_q.push_back(r);
	endfunction

	// advance the task table by one accepted operation and queue what it dispatches
	function automatic void predict_dispatch(sched_op_t t);
		logic [31:0] due;
		int          hits;
		bit          known;
		hits  = 0;
		known = t.id < task_cnt;
		case (t.op)
			petd_pkg::OP_TICK: begin
				tick_now = tick_now + 32'd1;
				for (int i = 0; i < task_cnt; i++) begin
					due = task_fired[i] + task_period[i];
					if (task_timer[i] && tick_now >= due) begin
						task_pend[i]  = 1'b1;
						task_fired[i] = tick_now;
					end
				end
				expect_result(petd_pkg::ACT_NONE, '0, petd_pkg::TS_INIT, 1'b0);
			end
			petd_pkg::OP_SCAN: begin
				for (int i = 0; i < task_cnt && hits < petd_pkg::RESULT_LIMIT; i++) begin
					if (task_st[i] == petd_pkg::TS_INIT) begin
						task_st[i] = petd_pkg::TS_IDLE;
						expect_result(petd_pkg::ACT_INIT, 4'(i), petd_pkg::TS_IDLE, 1'b0);
						hits++;
					end else if (task_st[i] == petd_pkg::TS_IDLE && task_pend[i]) begin
						task_pend[i] = 1'b0;
						task_st[i]   = petd_pkg::TS_EXEC;
						expect_result(petd_pkg::ACT_EXEC, 4'(i), petd_pkg::TS_EXEC, 1'b0);
						hits++;
					end
				end
				if (hits == 0)
					expect_result(petd_pkg::ACT_NONE, '0, petd_pkg::TS_INIT, 1'b0);
			end
			petd_pkg::OP_ADD: begin
				if (task_cnt >= petd_pkg::MAX_TASKS_DEF) begin
					expect_result(petd_pkg::ACT_NONE, '0, petd_pkg::TS_INIT, 1'b1);
				end else begin
					task_st[task_cnt]     = petd_pkg::TS_INIT;
					task_timer[task_cnt]  = t.kind;
					task_pend[task_cnt]   = 1'b0;
					task_period[task_cnt] = t.kind ? t.period : 32'd0;
					task_fired[task_cnt]  = 32'd0;
					expect_result(petd_pkg::ACT_NONE, 4'(task_cnt), petd_pkg::TS_INIT, 1'b0);
					task_cnt++;
				end
			end
			petd_pkg::OP_RAISE: begin
				if (known)
					task_pend[t.id] = 1'b1;
				expect_result(petd_pkg::ACT_NONE, t.id,
					known ? task_st[t.id] : petd_pkg::TS_INIT, 1'b0);
			end
			petd_pkg::OP_SET: begin
				if (known)
					task_st[t.id] = petd_pkg::tstate_t'(t.nst);
				expect_result(petd_pkg::ACT_NONE, t.id,
					known ? task_st[t.id] : petd_pkg::TS_INIT, 1'b0);
			end
			petd_pkg::OP_READ: begin
				expect_result(petd_pkg::ACT_NONE, t.id,
					known ? task_st[t.id] : petd_pkg::TS_INIT, 1'b0);
			end
			default: begin
				expect_result(petd_pkg::ACT_NONE, '0, petd_pkg::TS_INIT, 1'b0);
			end
		endcase
		result_q[result_q.size() - 1].is_last = 1'b1;
	endfunction

	// input driver: offers queued operations with random gaps, predicts on each transfer
	always @(posedge clk or negedge arst_n) begin
		sched_op_t nxt;
		if (!arst_n) begin
			in_valid     <= 1'b0;
			operation    <= '0;
			task_id      <= '0;
			task_kind    <= 1'b0;
			period_ticks <= '0;
			new_state    <= '0;
			send_gap     = 0;
			accepted_cnt = 0;
			task_cnt     = 0;
			tick_now     = '0;
			for (int i = 0; i < petd_pkg::MAX_TASKS_DEF; i++)
				task_pend[i] = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_dispatch(sched_op_t'{operation, task_id, task_kind, period_ticks,
					new_state});
				accepted_cnt++;
			end
			if (in_valid && !in_ready) begin
				// hold the offer until it is taken
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (op_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (op_q.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(0, 6);
				in_valid <= 1'b0;
			end else begin
				nxt = op_q.pop_front();
				in_valid     <= 1'b1;
				operation    <= nxt.op;
				task_id      <= nxt.id;
				task_kind    <= nxt.kind;
				period_ticks <= nxt.period;
				new_state    <= nxt.nst;
			end
		end
	end

	// receiver: random stall bursts, one long hold-off, steady at the tail
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
			hold_done  = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && accepted_cnt >= 60) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (op_q.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		sched_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				if (fail_cnt < 10)
					$display("unexpected result: act=%0d idx=%0d st=%0d full=%0b last=%0b",
						action, task_index, task_status, table_full, last);
				fail_cnt++;
			end else begin
				e = result_q.pop_front();
				if (action !== e.act || task_index !== e.idx || task_status !== e.st ||
						table_full !== e.full || last !== e.is_last) begin
					if (fail_cnt < 10)
						$display({"mismatch: exp act=%0d idx=%0d st=%0d full=%0b last=%0b,",
							" got act=%0d idx=%0d st=%0d full=%0b last=%0b"},
							e.act, e.idx, e.st, e.full, e.is_last,
							action, task_index, task_status, table_full, last);
					fail_cnt++;
				end
			end
		end
	end

	task automatic queue_op(logic [2:0] op, logic [3:0] id, logic kind, logic [31:0] period,
			logic [1:0] nst);
		op_q.push_back(sched_op_t'{op, id, kind, period, nst});
	endtask

	// stimulus, reset and end of run
	initial begin
		int         n_rand;
		int         regs;
		int         pick;
		bit         burst_done;
		logic [3:0] id;
		logic [31:0] per;
		logic [1:0] nst;
		fail_cnt     = 0;
		cycle_cnt    = 0;
		n_rand       = 0;
		regs         = 5;
		burst_done   = 1'b0;

		// directed: empty table, unregistered ids, spare codes, period extremes
		queue_op(petd_pkg::OP_TICK, 4'd0, 1'b0, 32'd0, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_SCAN, 4'd15, 1'b1, 32'hFFFF_FFFF, petd_pkg::TS_DEAD);
		queue_op(petd_pkg::OP_READ, 4'd15, 1'b0, 32'd0, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_RAISE, 4'd0, 1'b0, 32'd0, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_SET, 4'd3, 1'b0, 32'd0, petd_pkg::TS_DEAD);
		queue_op(OP_SPARE_LO, 4'd7, 1'b1, 32'h5A5A_A5A5, petd_pkg::TS_EXEC);
		queue_op(OP_SPARE_HI, 4'd8, 1'b0, 32'hA5A5_5A5A, petd_pkg::TS_IDLE);
		queue_op(petd_pkg::OP_ADD, 4'd0, 1'b0, 32'hFFFF_FFFF, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_ADD, 4'd0, 1'b1, 32'd0, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_ADD, 4'd0, 1'b1, 32'd1, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_ADD, 4'd0, 1'b1, 32'hFFFF_FFFF, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_ADD, 4'd0, 1'b1, 32'd2, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_SCAN, 4'd0, 1'b0, 32'd0, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_TICK, 4'd0, 1'b0, 32'd0, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_TICK, 4'd0, 1'b0, 32'd0, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_SCAN, 4'd0, 1'b0, 32'd0, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_RAISE, 4'd0, 1'b0, 32'd0, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_SCAN, 4'd0, 1'b0, 32'd0, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_SET, 4'd1, 1'b0, 32'd0, petd_pkg::TS_IDLE);
		queue_op(petd_pkg::OP_SET, 4'd2, 1'b0, 32'd0, petd_pkg::TS_DEAD);
		queue_op(petd_pkg::OP_READ, 4'd2, 1'b0, 32'd0, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_SET, 4'd3, 1'b0, 32'd0, petd_pkg::TS_EXEC);
		queue_op(petd_pkg::OP_TICK, 4'd0, 1'b0, 32'd0, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_SCAN, 4'd0, 1'b0, 32'd0, petd_pkg::TS_INIT);
		queue_op(petd_pkg::OP_READ, 4'd0, 1'b0, 32'd0, petd_pkg::TS_INIT);

		// random: mostly ops on registered tasks, with a full-table burst of dispatches
		while (n_rand < RAND_ITEMS) begin
			if (regs >= petd_pkg::MAX_TASKS_DEF && !burst_done) begin
				for (int i = 0; i < petd_pkg::MAX_TASKS_DEF; i++)
					queue_op(petd_pkg::OP_SET, 4'(i), 1'($urandom), $urandom,
						petd_pkg::TS_INIT);
				queue_op(petd_pkg::OP_SCAN, 4'($urandom), 1'($urandom), $urandom,
					2'($urandom));
				burst_done = 1'b1;
				n_rand += petd_pkg::MAX_TASKS_DEF + 1;
				continue;
			end
			pick = $urandom_range(0, 99);
			if (regs > 0 && $urandom_range(0, 6) != 0)
				id = 4'($urandom_range(0, regs - 1));
			else
				id = 4'($urandom);
			per = $urandom;
			nst = ($urandom_range(0, 1) == 0) ? petd_pkg::TS_IDLE : 2'($urandom);
			if (pick < 22) begin
				queue_op(petd_pkg::OP_TICK, id, 1'($urandom), per, nst);
			end else if (pick < 42) begin
				queue_op(petd_pkg::OP_SCAN, id, 1'($urandom), per, nst);
			end else if (pick < 52) begin
				if ($urandom_range(0, 1) == 0)
					per = $urandom_range(0, 6);
				queue_op(petd_pkg::OP_ADD, id, 1'($urandom), per, nst);
				if (regs < petd_pkg::MAX_TASKS_DEF)
					regs++;
			end else if (pick < 66) begin
				queue_op(petd_pkg::OP_RAISE, id, 1'($urandom), per, nst);
			end else if (pick < 82) begin
				queue_op(petd_pkg::OP_SET, id, 1'($urandom), per, nst);
			end else if (pick < 93) begin
				queue_op(petd_pkg::OP_READ, id, 1'($urandom), per, nst);
			end else begin
				queue_op($urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO, id, 1'($urandom),
					per, nst);
			end
			n_rand++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// drain: everything sent, every expected result seen, then a quiet spell
		while (op_q.size() != 0 || in_valid || result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
